// File: design/wall_follow_guidance_macros.svh
// assertion macros for the wall follow guidance checker
// no dependencies
`ifndef WALL_FOLLOW_GUIDANCE_MACROS_SVH
`define WALL_FOLLOW_GUIDANCE_MACROS_SVH
`define WFG_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define WFG_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: design/wfg_pkg.sv
// shared types and codes for the wall follow guidance block
// no dependencies
`timescale 1ns / 1ps
package wfg_pkg;
   typedef enum logic [1:0] {MODE_FOLLOW = 2'd0, MODE_SPIN_RIGHT = 2'd1,
                             MODE_SPIN_LEFT = 2'd2} mode_type;
   typedef enum logic [1:0] {ST_OK = 2'd0, ST_SKIP = 2'd1, ST_COLLISION = 2'd2} status_type;
   typedef enum logic [1:0] {STRAT_CENTRE = 2'd0, STRAT_RIGHT = 2'd1,
                             STRAT_LEFT = 2'd2} strategy_type;
   typedef enum logic [2:0] {CSR_STRATEGY = 3'd0, CSR_TARGET = 3'd1, CSR_MIN_SAFE = 3'd2,
                             CSR_FRONT_THR = 3'd3, CSR_SIDE_THR = 3'd4, CSR_FS_DIFF = 3'd5,
                             CSR_SLOW_THR = 3'd6, CSR_DEADBAND = 3'd7} csr_index_type;
   typedef enum logic [1:0] {PH_IDLE, PH_SUM, PH_DIV, PH_DONE} phase_type;
   localparam int DIST_W = 13;
   localparam int SUM_W = 17;
   // divider control from the top to the lanes
   typedef struct packed {
      logic start;
      logic [3:0] divisor;
   } lane_ctl_type;
endpackage

// File: design/wfg_lane.sv
// one averaging lane: ring of samples, running sum over the filled slots, restoring divider
// depends on wfg_pkg
`timescale 1ns / 1ps
module wfg_lane import wfg_pkg::*; #(
   parameter int DEPTH = 8,
   parameter int SLOT_W = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              sum_clear,
   input  logic              sum_add,
   input  logic [SLOT_W-1:0] rd_slot,
   input  logic              rd_new,
   input  logic [DIST_W-1:0] new_sample,
   input  logic              wr_en,
   input  logic [SLOT_W-1:0] wr_slot,
   input  lane_ctl_type      ctl,
   output logic [DIST_W-1:0] average,
   output logic              busy
);
   logic [DIST_W-1:0] ring_ff [DEPTH];
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [SUM_W-1:0] rem_ff, rem_in;
   logic [4:0] bit_ff, bit_in;
   logic busy_ff, busy_in;
   logic [DIST_W-1:0] addend;
   logic [SUM_W:0] trial;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_ff[wr_slot] <= new_sample;
      end
   end

   assign addend = rd_new ? new_sample : ring_ff[rd_slot];

   always_comb begin
      sum_in = sum_ff;
      if (sum_clear) begin
         sum_in = '0;
      end else if (sum_add) begin
         sum_in = sum_ff + SUM_W'(addend);
      end
   end

   // one quotient bit per cycle
   always_comb begin
      busy_in = busy_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      bit_in = bit_ff;
      trial = '0;
      if (ctl.start) begin
         busy_in = 1'b1;
         quo_in = sum_ff;
         rem_in = '0;
         bit_in = 5'(SUM_W);
      end else if (busy_ff) begin
         trial = {rem_ff, quo_ff[SUM_W-1]} - (SUM_W+1)'(ctl.divisor);
         if (!trial[SUM_W]) begin
            rem_in = trial[SUM_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[SUM_W-2:0], quo_ff[SUM_W-1]};
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
         bit_in = bit_ff - 5'd1;
         if (bit_ff == 5'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      sum_ff <= sum_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      bit_ff <= bit_in;
   end

   assign average = quo_ff[DIST_W-1:0];
   assign busy = busy_ff;
endmodule

// File: design/wfg_decide.sv
// merging stage: collision checks, wall flags, mode step and lateral error
// depends on wfg_pkg
`timescale 1ns / 1ps
module wfg_decide import wfg_pkg::*; (
   input  logic [DIST_W-1:0] fa,
   input  logic [DIST_W-1:0] ra,
   input  logic [DIST_W-1:0] la,
   input  logic [1:0]        strategy,
   input  logic [10:0]       wall_target,
   input  logic [10:0]       min_safe,
   input  logic [10:0]       front_thr,
   input  logic [10:0]       side_thr,
   input  logic [10:0]       fs_diff,
   input  logic [11:0]       slow_thr,
   input  logic [9:0]        deadband,
   input  mode_type          mode,
   input  logic [2:0]        flags,
   input  logic              slow,
   input  logic [DIST_W-1:0] front_turn,
   output status_type        status,
   output mode_type          mode_next,
   output logic [2:0]        flags_next,
   output logic              slow_next,
   output logic [DIST_W-1:0] front_turn_next,
   output logic [14:0]       lat_err
);
   logic nfb, nrb, nlb, fnz;
   logic [11:0] fs_target, side_target;
   logic [13:0] spin_lim;
   logic signed [15:0] err, mag;

   always_comb begin
      fnz = fa != '0;
      fs_target = 12'(fs_diff) + 12'(wall_target);
      side_target = 12'(side_thr) + 12'(wall_target);
      nfb = flags[2];
      nrb = flags[1];
      nlb = flags[0];
      status = ST_OK;
      if (ra == '0 || la == '0) begin
         status = ST_SKIP;
      end else if (fnz && fa < DIST_W'(min_safe)) begin
         status = ST_COLLISION;
      end else begin
         case (strategy)
            STRAT_CENTRE: begin
               if (la < DIST_W'(min_safe) || ra < DIST_W'(min_safe)) begin
                  status = ST_COLLISION;
               end else begin
                  nfb = fnz && fa < DIST_W'(front_thr);
                  nrb = ra < DIST_W'(side_thr);
                  nlb = la < DIST_W'(side_thr);
               end
            end
            STRAT_RIGHT: begin
               if (ra < DIST_W'(min_safe)) begin
                  status = ST_COLLISION;
               end else begin
                  nfb = fnz && fa < DIST_W'(fs_target);
                  nrb = ra < DIST_W'(side_target);
               end
            end
            STRAT_LEFT: begin
               if (la < DIST_W'(min_safe)) begin
                  status = ST_COLLISION;
               end else begin
                  nfb = fnz && fa < DIST_W'(fs_target);
                  nlb = la < DIST_W'(side_target);
               end
            end
            default: status = ST_COLLISION;
         endcase
      end
      flags_next = {nfb, nrb, nlb};
      mode_next = mode;
      slow_next = slow;
      front_turn_next = front_turn;
      spin_lim = 14'(front_turn) + 14'(fs_diff);
      case (mode)
         MODE_FOLLOW: begin
            if (nfb) begin
               mode_next = (nrb && !nlb) ? MODE_SPIN_LEFT : MODE_SPIN_RIGHT;
               front_turn_next = fa;
               slow_next = 1'b0;
            end else begin
               slow_next = fnz && fa < DIST_W'(slow_thr);
            end
         end
         MODE_SPIN_RIGHT: begin
            if (!nfb && nlb && 14'(la) < spin_lim) mode_next = MODE_FOLLOW;
         end
         default: begin
            if (!nfb && nrb && 14'(ra) < spin_lim) mode_next = MODE_FOLLOW;
         end
      endcase
      case (strategy)
         STRAT_CENTRE: err = ($signed({3'b0, ra}) - $signed({3'b0, la})) / 16'sd2
                             - $signed({5'b0, wall_target});
         STRAT_RIGHT: err = $signed({3'b0, ra}) - $signed({5'b0, wall_target});
         default: err = $signed({5'b0, wall_target}) - $signed({3'b0, la});
      endcase
      mag = err[15] ? -err : err;
      if (mag < $signed({6'b0, deadband})) err = '0;
      lat_err = (status == ST_OK && mode_next == MODE_FOLLOW) ? err[14:0] : '0;
   end
endmodule

// File: design/wall_follow_guidance.sv
// wall follow guidance: three averaging lanes feed one decision stage
// depends on wfg_pkg, wfg_lane, wfg_decide
// usage:
//  req_ carries one front, right and left sample plus restart; rsp_ carries one result.
//  an item is a transfer when valid is high and stall low on that channel.
//  one item at a time: req_stall is high from acceptance until the result is loaded.
//  sequence: the ring is summed over the filled slots, then the bit-serial dividers
//  run (start, 17 quotient bits, finish; all three lanes in step), then the decision
//  stage result is loaded into the output register and rsp_valid rises.
//  req_stall drops as rsp_valid rises, and the next transfer can be accepted while
//  that result is shown.
//  the result stays in its output register while rsp_stall is high; a following
//  item waits after its divide until that result has been taken.
//  csr_ writes take effect at once and must only be made while idle.
//  synchronous reset loads the register defaults, clears the fill count,
//  write slot, flags and mode; ring contents are left as they were.
`timescale 1ns / 1ps
module wall_follow_guidance import wfg_pkg::*; #(
   parameter int WINDOW_SAMPLES = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [12:0]       req_front_mm,
   input  logic [12:0]       req_right_mm,
   input  logic [12:0]       req_left_mm,
   input  logic              req_restart,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [1:0]        rsp_motion_mode,
   output logic              rsp_slow_request,
   output logic              rsp_front_is_blocked,
   output logic              rsp_right_is_blocked,
   output logic              rsp_left_is_blocked,
   output logic signed [14:0] rsp_lateral_error,
   output logic [12:0]       rsp_front_average,
   output logic [12:0]       rsp_right_average,
   output logic [12:0]       rsp_left_average,
   input  logic              csr_write,
   input  logic [2:0]        csr_index,
   input  logic [11:0]       csr_data
);
   localparam int SLOT_W = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;

   logic [1:0] strategy_ff;
   logic [10:0] target_ff, min_safe_ff, front_thr_ff, side_thr_ff, fs_diff_ff;
   logic [11:0] slow_thr_ff;
   logic [9:0] deadband_ff;

   phase_type phase_ff, phase_in;
   logic [SLOT_W-1:0] slot_ff, slot_in, rd_ff, rd_in;
   logic [3:0] filled_ff, filled_in, cnt_ff, cnt_in;
   mode_type mode_ff, mode_in;
   logic [2:0] flags_ff, flags_in;
   logic slow_ff, slow_in;
   logic [DIST_W-1:0] turn_ff, turn_in;
   logic [DIST_W-1:0] f_ff, r_ff, l_ff;
   logic [3:0] step_ff, step_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] o_status_ff;
   logic [1:0] o_mode_ff;
   logic o_slow_ff;
   logic [2:0] o_flags_ff;
   logic [14:0] o_err_ff;
   logic [DIST_W-1:0] o_fa_ff, o_ra_ff, o_la_ff;

   logic accept, sum_clear, sum_add, rd_new, wr_en;
   lane_ctl_type ctl;
   logic [DIST_W-1:0] fa, ra, la;
   logic fbusy, rbusy, lbusy;
   status_type d_status;
   mode_type d_mode;
   logic [2:0] d_flags;
   logic d_slow;
   logic [DIST_W-1:0] d_turn;
   logic [14:0] d_err;

   always_ff @(posedge clock) begin
      if (reset) begin
         strategy_ff <= 2'd0;
         target_ff <= 11'd100;
         min_safe_ff <= 11'd50;
         front_thr_ff <= 11'd200;
         side_thr_ff <= 11'd200;
         fs_diff_ff <= 11'd50;
         slow_thr_ff <= 12'd400;
         deadband_ff <= 10'd10;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_STRATEGY: strategy_ff <= csr_data[1:0];
            CSR_TARGET: target_ff <= csr_data[10:0];
            CSR_MIN_SAFE: min_safe_ff <= csr_data[10:0];
            CSR_FRONT_THR: front_thr_ff <= csr_data[10:0];
            CSR_SIDE_THR: side_thr_ff <= csr_data[10:0];
            CSR_FS_DIFF: fs_diff_ff <= csr_data[10:0];
            CSR_SLOW_THR: slow_thr_ff <= csr_data;
            CSR_DEADBAND: deadband_ff <= csr_data[9:0];
            default: ;
         endcase
      end
   end

   assign accept = req_valid && !req_stall;
   assign req_stall = phase_ff != PH_IDLE;

   always_comb begin
      phase_in = phase_ff;
      slot_in = slot_ff;
      rd_in = rd_ff;
      filled_in = filled_ff;
      cnt_in = cnt_ff;
      mode_in = mode_ff;
      flags_in = flags_ff;
      slow_in = slow_ff;
      turn_in = turn_ff;
      step_in = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      sum_clear = 1'b0;
      sum_add = 1'b0;
      wr_en = 1'b0;
      ctl.start = 1'b0;
      ctl.divisor = cnt_ff;
      rd_new = rd_ff == slot_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (accept) begin
               if (req_restart) begin
                  slot_in = '0;
                  filled_in = '0;
                  mode_in = MODE_FOLLOW;
                  flags_in = '0;
                  slow_in = 1'b0;
                  turn_in = '0;
               end
               cnt_in = (req_restart || filled_ff >= 4'(WINDOW_SAMPLES)) ?
                        (req_restart ? 4'd1 : 4'(WINDOW_SAMPLES)) : filled_ff + 4'd1;
               if (!req_restart && slot_ff >= SLOT_W'(WINDOW_SAMPLES - 1) &&
                   32'(slot_ff) >= WINDOW_SAMPLES) slot_in = '0;
               rd_in = '0;
               step_in = '0;
               sum_clear = 1'b1;
               phase_in = PH_SUM;
            end
         end
         PH_SUM: begin
            sum_add = 1'b1;
            rd_in = rd_ff + SLOT_W'(1);
            step_in = step_ff + 4'd1;
            if (step_ff + 4'd1 == cnt_ff) begin
               phase_in = PH_DIV;
               step_in = '0;
            end
         end
         PH_DIV: begin
            if (step_ff == '0) begin
               ctl.start = 1'b1;
               step_in = 4'd1;
            end else if (!fbusy && !rbusy && !lbusy && !rsp_valid_ff) begin
               phase_in = PH_DONE;
            end
         end
         default: begin
            rsp_valid_in = 1'b1;
            if (d_status == ST_OK) begin
               wr_en = 1'b1;
               slot_in = (32'(slot_ff) + 1 < WINDOW_SAMPLES) ? slot_ff + SLOT_W'(1) : '0;
               filled_in = cnt_ff;
               mode_in = d_mode;
               flags_in = d_flags;
               slow_in = d_slow;
               turn_in = d_turn;
            end
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         slot_ff <= '0;
         filled_ff <= '0;
         mode_ff <= MODE_FOLLOW;
         flags_ff <= '0;
         slow_ff <= 1'b0;
         turn_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         slot_ff <= slot_in;
         filled_ff <= filled_in;
         mode_ff <= mode_in;
         flags_ff <= flags_in;
         slow_ff <= slow_in;
         turn_ff <= turn_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_ff <= rd_in;
      cnt_ff <= cnt_in;
      step_ff <= step_in;
      if (accept) begin
         f_ff <= req_front_mm;
         r_ff <= req_right_mm;
         l_ff <= req_left_mm;
      end
      if (phase_ff == PH_DONE) begin
         o_status_ff <= d_status;
         o_mode_ff <= (d_status == ST_OK) ? d_mode : mode_ff;
         o_slow_ff <= (d_status == ST_OK) ? d_slow : slow_ff;
         o_flags_ff <= (d_status == ST_OK) ? d_flags : flags_ff;
         o_err_ff <= d_err;
         o_fa_ff <= fa;
         o_ra_ff <= ra;
         o_la_ff <= la;
      end
   end

   wfg_lane #(.DEPTH(WINDOW_SAMPLES), .SLOT_W(SLOT_W)) u_front (
      .clock, .reset, .sum_clear, .sum_add, .rd_slot(rd_ff), .rd_new,
      .new_sample(f_ff), .wr_en, .wr_slot(slot_ff), .ctl, .average(fa), .busy(fbusy));
   wfg_lane #(.DEPTH(WINDOW_SAMPLES), .SLOT_W(SLOT_W)) u_right (
      .clock, .reset, .sum_clear, .sum_add, .rd_slot(rd_ff), .rd_new,
      .new_sample(r_ff), .wr_en, .wr_slot(slot_ff), .ctl, .average(ra), .busy(rbusy));
   wfg_lane #(.DEPTH(WINDOW_SAMPLES), .SLOT_W(SLOT_W)) u_left (
      .clock, .reset, .sum_clear, .sum_add, .rd_slot(rd_ff), .rd_new,
      .new_sample(l_ff), .wr_en, .wr_slot(slot_ff), .ctl, .average(la), .busy(lbusy));

   wfg_decide u_decide (
      .fa, .ra, .la, .strategy(strategy_ff), .wall_target(target_ff),
      .min_safe(min_safe_ff), .front_thr(front_thr_ff), .side_thr(side_thr_ff),
      .fs_diff(fs_diff_ff), .slow_thr(slow_thr_ff), .deadband(deadband_ff),
      .mode(mode_ff), .flags(flags_ff), .slow(slow_ff), .front_turn(turn_ff),
      .status(d_status), .mode_next(d_mode), .flags_next(d_flags), .slow_next(d_slow),
      .front_turn_next(d_turn), .lat_err(d_err));

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = o_status_ff;
   assign rsp_motion_mode = o_mode_ff;
   assign rsp_slow_request = o_slow_ff;
   assign rsp_front_is_blocked = o_flags_ff[2];
   assign rsp_right_is_blocked = o_flags_ff[1];
   assign rsp_left_is_blocked = o_flags_ff[0];
   assign rsp_lateral_error = o_err_ff;
   assign rsp_front_average = o_fa_ff;
   assign rsp_right_average = o_ra_ff;
   assign rsp_left_average = o_la_ff;
endmodule

// File: design/wfg_checker.sv
// port level checker for wall_follow_guidance, bound to the top level
// depends on wall_follow_guidance_macros.svh and wfg_pkg
`timescale 1ns / 1ps
`include "wall_follow_guidance_macros.svh"
module wfg_checker import wfg_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [1:0]  rsp_motion_mode,
   input logic signed [14:0] rsp_lateral_error
);
   `WFG_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status), "stalled result changed")
   `WFG_ASSERT(a_busy_after_accept, clock, reset, req_valid && !req_stall |=> req_stall, "block took a second transfer")
   `WFG_ASSERT(a_err_zero, clock, reset, rsp_valid && (rsp_status != ST_OK || rsp_motion_mode != MODE_FOLLOW) |-> rsp_lateral_error == '0, "lateral error outside follow")
   `WFG_ASSERT_NR(a_reset_idle, clock, $past(reset) && !reset |-> !rsp_valid && !req_stall, "not idle after reset")
endmodule

bind wall_follow_guidance wfg_checker u_wfg_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
   .rsp_status, .rsp_motion_mode, .rsp_lateral_error);

// File: tb/tb_wall_follow_guidance.sv
// self-checking testbench for wall_follow_guidance: directed and random samples
// with random idling on both sides, results checked against an in-bench predictor
// depends on wfg_pkg and the wall_follow_guidance rtl
`timescale 1ns / 1ps

typedef struct {
   wfg_pkg::status_type st;
   wfg_pkg::mode_type md;
   logic slow, fb, rb, lb;
   logic signed [14:0] err;
   logic [12:0] fa, ra, la;
} guidance_result_type;

class guidance_scoreboard;
   int unsigned strategy_r, target_r, min_safe_r, front_thr_r, side_thr_r;
   int unsigned fs_diff_r, slow_thr_r, deadband_r;
   int unsigned ring_f[8], ring_r[8], ring_l[8];
   int unsigned slot_r, filled_r, front_turn_r;
   wfg_pkg::mode_type mode_r;
   bit fb_r, rb_r, lb_r, slow_r;
   guidance_result_type pending[$];
   int errors;
   int checked;

   function new();
      errors = 0;
      checked = 0;
      strategy_r = 0; target_r = 100; min_safe_r = 50; front_thr_r = 200;
      side_thr_r = 200; fs_diff_r = 50; slow_thr_r = 400; deadband_r = 10;
      clear_run();
   endfunction

   function void clear_run();
      slot_r = 0; filled_r = 0; front_turn_r = 0;
      mode_r = wfg_pkg::MODE_FOLLOW;
      fb_r = 0; rb_r = 0; lb_r = 0; slow_r = 0;
   endfunction

   function void set_reg(wfg_pkg::csr_index_type idx, logic [11:0] v);
      case (idx)
         wfg_pkg::CSR_STRATEGY: strategy_r = v[1:0];
         wfg_pkg::CSR_TARGET: target_r = v[10:0];
         wfg_pkg::CSR_MIN_SAFE: min_safe_r = v[10:0];
         wfg_pkg::CSR_FRONT_THR: front_thr_r = v[10:0];
         wfg_pkg::CSR_SIDE_THR: side_thr_r = v[10:0];
         wfg_pkg::CSR_FS_DIFF: fs_diff_r = v[10:0];
         wfg_pkg::CSR_SLOW_THR: slow_thr_r = v[11:0];
         default: deadband_r = v[9:0];
      endcase
   endfunction

   function void note_sample(logic [12:0] f, logic [12:0] r, logic [12:0] l, logic rst);
      guidance_result_type x;
      int unsigned cnt, fs, rs, ls, fa, ra, la;
      int e, ae;
      bit nfb, nrb, nlb;
      wfg_pkg::status_type st;
      if (rst) clear_run();
      cnt = (filled_r < 8) ? filled_r + 1 : 8;
      fs = 0; rs = 0; ls = 0;
      for (int i = 0; i < cnt; i++) begin
         fs += (i == slot_r) ? f : ring_f[i];
         rs += (i == slot_r) ? r : ring_r[i];
         ls += (i == slot_r) ? l : ring_l[i];
      end
      fa = fs / cnt; ra = rs / cnt; la = ls / cnt;
      nfb = fb_r; nrb = rb_r; nlb = lb_r;
      st = wfg_pkg::ST_OK;
      e = 0;
      if (ra == 0 || la == 0) begin
         st = wfg_pkg::ST_SKIP;
      end else if (fa != 0 && fa < min_safe_r) begin
         st = wfg_pkg::ST_COLLISION;
      end else if (strategy_r == wfg_pkg::STRAT_CENTRE) begin
         if (la < min_safe_r || ra < min_safe_r) st = wfg_pkg::ST_COLLISION;
         else begin
            nfb = fa != 0 && fa < front_thr_r;
            nrb = ra < side_thr_r;
            nlb = la < side_thr_r;
         end
      end else if (strategy_r == wfg_pkg::STRAT_RIGHT) begin
         if (ra < min_safe_r) st = wfg_pkg::ST_COLLISION;
         else begin
            nfb = fa != 0 && fa < fs_diff_r + target_r;
            nrb = ra < side_thr_r + target_r;
         end
      end else if (strategy_r == wfg_pkg::STRAT_LEFT) begin
         if (la < min_safe_r) st = wfg_pkg::ST_COLLISION;
         else begin
            nfb = fa != 0 && fa < fs_diff_r + target_r;
            nlb = la < side_thr_r + target_r;
         end
      end else begin
         st = wfg_pkg::ST_COLLISION;
      end
      if (st == wfg_pkg::ST_OK) begin
         ring_f[slot_r] = f; ring_r[slot_r] = r; ring_l[slot_r] = l;
         slot_r = (slot_r + 1 < 8) ? slot_r + 1 : 0;
         filled_r = cnt;
         fb_r = nfb; rb_r = nrb; lb_r = nlb;
         if (mode_r == wfg_pkg::MODE_FOLLOW) begin
            if (fb_r) begin
               if (!rb_r) mode_r = wfg_pkg::MODE_SPIN_RIGHT;
               else if (!lb_r) mode_r = wfg_pkg::MODE_SPIN_LEFT;
               else mode_r = wfg_pkg::MODE_SPIN_RIGHT;
               front_turn_r = fa;
               slow_r = 0;
            end else begin
               slow_r = fa != 0 && fa < slow_thr_r;
            end
         end else if (mode_r == wfg_pkg::MODE_SPIN_RIGHT) begin
            if (!fb_r && lb_r && la < front_turn_r + fs_diff_r) mode_r = wfg_pkg::MODE_FOLLOW;
         end else begin
            if (!fb_r && rb_r && ra < front_turn_r + fs_diff_r) mode_r = wfg_pkg::MODE_FOLLOW;
         end
         if (mode_r == wfg_pkg::MODE_FOLLOW) begin
            if (strategy_r == wfg_pkg::STRAT_CENTRE) e = (int'(ra) - int'(la)) / 2 - int'(target_r);
            else if (strategy_r == wfg_pkg::STRAT_RIGHT) e = int'(ra) - int'(target_r);
            else e = int'(target_r) - int'(la);
            ae = (e < 0) ? -e : e;
            if (ae < int'(deadband_r)) e = 0;
         end
      end
      x.st = st; x.md = mode_r; x.slow = slow_r;
      x.fb = fb_r; x.rb = rb_r; x.lb = lb_r;
      x.err = e[14:0];
      x.fa = fa[12:0]; x.ra = ra[12:0]; x.la = la[12:0];
      pending.push_back(x);
   endfunction

   function void report(string what, int got, int want);
      errors++;
      if (errors <= 30) $display("mismatch on transfer %0d: %s got %0d expected %0d",
                                 checked, what, got, want);
   endfunction

   function void check_result(guidance_result_type g);
      guidance_result_type w;
      if (pending.size() == 0) begin
         report("unexpected result", 1, 0);
         return;
      end
      w = pending.pop_front();
      if (g.st != w.st) report("status", g.st, w.st);
      if (g.md != w.md) report("motion_mode", g.md, w.md);
      if (g.slow != w.slow) report("slow_request", g.slow, w.slow);
      if (g.fb != w.fb) report("front_is_blocked", g.fb, w.fb);
      if (g.rb != w.rb) report("right_is_blocked", g.rb, w.rb);
      if (g.lb != w.lb) report("left_is_blocked", g.lb, w.lb);
      if (g.err != w.err) report("lateral_error", g.err, w.err);
      if (g.fa != w.fa) report("front_average", g.fa, w.fa);
      if (g.ra != w.ra) report("right_average", g.ra, w.ra);
      if (g.la != w.la) report("left_average", g.la, w.la);
      checked++;
   endfunction
endclass

module tb_wall_follow_guidance;
   import wfg_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_restart = 0;
   logic req_stall;
   logic [12:0] req_front_mm = 0, req_right_mm = 0, req_left_mm = 0;
   logic rsp_valid, rsp_stall = 0;
   logic [1:0] rsp_status, rsp_motion_mode;
   logic rsp_slow_request, rsp_front_is_blocked, rsp_right_is_blocked, rsp_left_is_blocked;
   logic signed [14:0] rsp_lateral_error;
   logic [12:0] rsp_front_average, rsp_right_average, rsp_left_average;
   logic csr_write = 0;
   logic [2:0] csr_index = 0;
   logic [11:0] csr_data = 0;

   guidance_scoreboard board = new();
   int send_idle = 0, stall_pct = 0;
   int sent = 0;

   always #10 clock = ~clock;

   wall_follow_guidance dut (.*);

   // result side: random stall, check on each transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         guidance_result_type g;
         g.st = status_type'(rsp_status);
         g.md = mode_type'(rsp_motion_mode);
         g.slow = rsp_slow_request; g.fb = rsp_front_is_blocked;
         g.rb = rsp_right_is_blocked; g.lb = rsp_left_is_blocked;
         g.err = rsp_lateral_error;
         g.fa = rsp_front_average; g.ra = rsp_right_average; g.la = rsp_left_average;
         board.check_result(g);
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // valid stays high after a transfer until the next item or an idle cycle
   task automatic send_sample(logic [12:0] f, logic [12:0] r, logic [12:0] l, logic rs);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_front_mm <= f; req_right_mm <= r; req_left_mm <= l; req_restart <= rs;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_sample(f, r, l, rs);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [11:0] v);
      csr_write <= 1; csr_index <= idx; csr_data <= v;
      @(posedge clock);
      csr_write <= 0;
      board.set_reg(idx, v);
      @(posedge clock);
   endtask

   // mostly plausible corridor samples, some extremes and zeros
   function automatic logic [12:0] pick_dist();
      int k;
      k = $urandom_range(99);
      if (k < 70) return 13'($urandom_range(40, 900));
      if (k < 80) return 13'($urandom_range(0, 8191));
      if (k < 85) return 13'd0;
      if (k < 90) return 13'h1fff;
      return 13'($urandom_range(1, 120));
   endfunction

   task automatic random_run(int n);
      for (int i = 0; i < n; i++)
         send_sample(pick_dist(), pick_dist(), pick_dist(), $urandom_range(99) < 4);
   endtask

   task automatic random_config();
      write_reg(CSR_STRATEGY, 12'($urandom_range(2)));
      write_reg(CSR_TARGET, 12'($urandom_range(0, 400)));
      write_reg(CSR_MIN_SAFE, 12'($urandom_range(0, 120)));
      write_reg(CSR_FRONT_THR, 12'($urandom_range(0, 700)));
      write_reg(CSR_SIDE_THR, 12'($urandom_range(0, 700)));
      write_reg(CSR_FS_DIFF, 12'($urandom_range(0, 300)));
      write_reg(CSR_SLOW_THR, 12'($urandom_range(0, 1200)));
      write_reg(CSR_DEADBAND, 12'($urandom_range(0, 100)));
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: defaults, skip, collision, spins, extremes
      send_sample(13'd500, 13'd300, 13'd300, 1);
      send_sample(13'd0, 13'd0, 13'd300, 0);
      send_sample(13'd30, 13'd300, 13'd300, 0);
      send_sample(13'd150, 13'd100, 13'd500, 0);
      send_sample(13'd100, 13'd100, 13'd500, 0);
      send_sample(13'd900, 13'd100, 13'd100, 0);
      send_sample(13'd900, 13'd120, 13'd80, 0);
      send_sample(13'h1fff, 13'h1fff, 13'h1fff, 1);
      send_sample(13'h1fff, 13'h1fff, 13'h1fff, 0);
      send_sample(13'd0, 13'd1, 13'd8190, 0);
      send_sample(13'h1555, 13'h0aaa, 13'h1555, 1);
      send_sample(13'h0aaa, 13'h1555, 13'h0aaa, 0);
      send_sample(13'd0, 13'd0, 13'd0, 1);
      drain();
      write_reg(CSR_STRATEGY, 12'd3);
      send_sample(13'd500, 13'd300, 13'd300, 0);
      drain();
      write_reg(CSR_STRATEGY, 12'(STRAT_RIGHT));
      write_reg(CSR_TARGET, 12'd2000);
      write_reg(CSR_MIN_SAFE, 12'd0);
      write_reg(CSR_FRONT_THR, 12'd2000);
      write_reg(CSR_SIDE_THR, 12'd2000);
      write_reg(CSR_FS_DIFF, 12'd2000);
      write_reg(CSR_SLOW_THR, 12'd4000);
      write_reg(CSR_DEADBAND, 12'd1000);
      send_sample(13'd3000, 13'd500, 13'd500, 1);
      send_sample(13'd4500, 13'd4000, 13'd4000, 0);
      drain();
      write_reg(CSR_STRATEGY, 12'(STRAT_LEFT));
      write_reg(CSR_TARGET, 12'd0);
      write_reg(CSR_FS_DIFF, 12'd0);
      write_reg(CSR_DEADBAND, 12'd0);
      write_reg(CSR_SLOW_THR, 12'hfff);
      send_sample(13'd200, 13'd300, 13'd150, 1);
      send_sample(13'd200, 13'd300, 13'd150, 0);
      drain();
      write_reg(CSR_STRATEGY, 12'(STRAT_CENTRE));
      write_reg(CSR_DEADBAND, 12'h3ff);
      send_sample(13'd900, 13'd301, 13'd100, 1);
      drain();
      // random phases with different idling
      for (int p = 0; p < 8; p++) begin
         case (p % 4)
            0: begin send_idle = 0; stall_pct = 0; end
            1: begin send_idle = 71; stall_pct = 0; end
            2: begin send_idle = 0; stall_pct = 71; end
            default: begin send_idle = 24; stall_pct = 24; end
         endcase
         drain();
         random_config();
         random_run(40);
         drain();
         random_run(45);
      end
      drain();
      $display("covered %0d sample transfers, %0d results checked, all strategies and",
               sent, board.checked);
      $display("register extremes, under four idling patterns");
      if (board.errors == 0 && board.pending.size() == 0)
         $display("wall_follow_guidance regression: pass");
      else
         $display("wall_follow_guidance regression: fail");
      $finish;
   end

   initial begin
      #20000000;
      $display("wall_follow_guidance regression: fail");
      $finish;
   end
endmodule
